// ===== src/running_mean_variance_defines.svh =====
// Assertion macros for the running mean and variance block.
`ifndef RUNNING_MEAN_VARIANCE_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_DEFINES_SVH

`ifndef SYNTHESIS
`define RMV_CHECK(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("running_mean_variance: check failed");
`define RMV_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("running_mean_variance: implication failed");
`else
`define RMV_CHECK(lbl, cond)
`define RMV_IMPLIES(lbl, ante, cons)
`endif

`endif

// ===== src/rmv_pkg.sv =====
// Shared types and constants for the running mean and variance block.
`timescale 1ns / 1ps
package rmv_pkg;

  localparam int COUNT_BITS = 32;
  localparam int SUM_BITS   = 64;
  localparam int PORT_BITS  = 32;
  localparam int HI_BITS    = COUNT_BITS + 1;
  localparam int ADD_BITS   = COUNT_BITS + 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_MEAN = 6'b000100,
    ST_PREP = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_ACC  = 6'b100000
  } state_t;

  typedef struct packed {
    logic idle;
    logic load_div;
    logic div_step;
    logic mean_upd;
    logic load_mul;
    logic mul_step;
    logic finish;
  } rmv_ctl_t;

endpackage

// ===== src/rmv_ctrl.sv =====
// Sequencer: steps the shared unit through divide, mean update and multiply.
`timescale 1ns / 1ps
module rmv_ctrl #(
  parameter int STEPS = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             out_free,
  output rmv_pkg::rmv_ctl_t ctl
);
  import rmv_pkg::*;

  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        ctl.idle     = 1'b1;
        ctl.load_div = start;
        if (start) begin
          state_next = ST_DIV;
          cnt_next   = LAST;
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_MEAN;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_MEAN: begin
        ctl.mean_upd = 1'b1;
        state_next   = ST_PREP;
      end
      ST_PREP: begin
        ctl.load_mul = 1'b1;
        state_next   = ST_MUL;
        cnt_next     = LAST;
      end
      ST_MUL: begin
        ctl.mul_step = 1'b1;
        if (cnt == '0) begin
          state_next = ST_ACC;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_ACC: begin
        ctl.finish = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/rmv_unit.sv =====
// Shared add/subtract unit: restoring divide steps and shift-add multiply steps.
`timescale 1ns / 1ps
module rmv_unit #(
  parameter int MAG_BITS = 33
) (
  input  logic                              clk,
  input  rmv_pkg::rmv_ctl_t                 ctl,
  input  logic [MAG_BITS-1:0]               ld_lo,
  input  logic [rmv_pkg::HI_BITS-1:0]       ld_opd,
  output logic [MAG_BITS-1:0]               quotient,
  output logic [2*MAG_BITS-1:0]             product
);
  import rmv_pkg::*;

  logic [HI_BITS-1:0]  hi;
  logic [MAG_BITS-1:0] lo;
  logic [HI_BITS-1:0]  opd;
  logic [HI_BITS-1:0]  shifted;
  logic [ADD_BITS-1:0] op_a, op_b, sum;
  logic                neg;

  always_comb begin
    shifted = {hi[COUNT_BITS-1:0], lo[MAG_BITS-1]};
    op_a    = ctl.div_step ? ADD_BITS'(shifted) : ADD_BITS'(hi);
    op_b    = (ctl.div_step || lo[0]) ? ADD_BITS'(opd) : '0;
    sum     = ctl.div_step ? (op_a + ~op_b + ADD_BITS'(1)) : (op_a + op_b);
    neg     = sum[ADD_BITS-1];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_div || ctl.load_mul) begin
      hi  <= '0;
      lo  <= ld_lo;
      opd <= ld_opd;
    end else if (ctl.div_step) begin
      hi <= neg ? shifted : sum[HI_BITS-1:0];
      lo <= {lo[MAG_BITS-2:0], ~neg};
    end else if (ctl.mul_step) begin
      hi <= HI_BITS'(sum[MAG_BITS:1]);
      lo <= {sum[0], lo[MAG_BITS-1:1]};
    end
  end

  assign quotient = lo;
  assign product  = {hi[MAG_BITS-1:0], lo};

endmodule

// ===== src/running_mean_variance.sv =====
// Top level: running count, mean, squared-deviation sum, minimum and maximum.
//
//  channel | valid        | stall        | word
//  --------+--------------+--------------+---------------------------------------------
//  in      | sample_valid | sample_stall | sample
//  out     | result_valid | result_stall | sample_count running_mean sum_sq_dev min max
//
// Result valid is set after the divide steps, mean update, multiply load, multiply steps and
// final accumulate that follow an accepted word; the next word is accepted once idle again.
// The shared add/subtract unit runs once per quotient bit of delta/count and
// once per multiplier bit of the deviation product.
// Synchronous reset clears all statistics and the result valid.
// A stalled result holds the block in its last step; input stalls while busy.
`timescale 1ns / 1ps
`include "running_mean_variance_defines.svh"
module running_mean_variance #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [rmv_pkg::PORT_BITS-1:0] sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [rmv_pkg::COUNT_BITS-1:0]       sample_count,
  output logic signed [rmv_pkg::PORT_BITS-1:0] running_mean,
  output logic [rmv_pkg::SUM_BITS-1:0]         sum_sq_dev,
  output logic signed [rmv_pkg::PORT_BITS-1:0] minimum,
  output logic signed [rmv_pkg::PORT_BITS-1:0] maximum
);
  import rmv_pkg::*;

  localparam int MAG_BITS = SAMPLE_BITS + 1;
  localparam int EXT_BITS = SAMPLE_BITS + 2;

  rmv_ctl_t ctl;

  logic signed [SAMPLE_BITS-1:0] x_in, x_reg, mean_reg, min_reg, max_reg;
  logic [COUNT_BITS-1:0]         count_reg, count_next;
  logic [SUM_BITS-1:0]           sq_dev_reg, sq_dev_next, prod64;
  logic [SUM_BITS:0]             sq_sum;
  logic                          delta_neg;
  logic [MAG_BITS-1:0]           delta_mag, mag_in, mag_x, ld_lo, quotient;
  logic signed [MAG_BITS-1:0]    diff_in, diff_x;
  logic [HI_BITS-1:0]            ld_opd;
  logic [2*MAG_BITS-1:0]         product;
  logic signed [EXT_BITS-1:0]    step, mean_sum;
  logic                          start, out_free, first;

  assign x_in         = sample[SAMPLE_BITS-1:0];
  assign start        = sample_valid && ctl.idle;
  assign sample_stall = !ctl.idle;
  assign out_free     = !result_valid || !result_stall;
  assign first        = (count_reg == '0);

  always_comb begin
    diff_in     = MAG_BITS'(x_in) - MAG_BITS'(mean_reg);
    diff_x      = MAG_BITS'(x_reg) - MAG_BITS'(mean_reg);
    mag_in      = diff_in[MAG_BITS-1] ? -diff_in : diff_in;
    mag_x       = diff_x[MAG_BITS-1] ? -diff_x : diff_x;
    count_next  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    ld_lo       = ctl.load_div ? mag_in : mag_x;
    ld_opd      = ctl.load_div ? HI_BITS'(count_next) : HI_BITS'(delta_mag);
    step        = delta_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    mean_sum    = EXT_BITS'(mean_reg) + step;
    prod64      = SUM_BITS'(product);
    sq_sum      = {1'b0, sq_dev_reg} + {1'b0, prod64};
    sq_dev_next = sq_sum[SUM_BITS] ? '1 : sq_sum[SUM_BITS-1:0];
  end

  rmv_ctrl #(
    .STEPS (MAG_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .ctl      (ctl)
  );

  rmv_unit #(
    .MAG_BITS (MAG_BITS)
  ) u_unit (
    .clk      (clk),
    .ctl      (ctl),
    .ld_lo    (ld_lo),
    .ld_opd   (ld_opd),
    .quotient (quotient),
    .product  (product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg    <= '0;
      mean_reg     <= '0;
      sq_dev_reg   <= '0;
      min_reg      <= '0;
      max_reg      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (start) begin
        count_reg <= count_next;
        if (first || x_in < min_reg) begin
          min_reg <= x_in;
        end
        if (first || x_in > max_reg) begin
          max_reg <= x_in;
        end
      end
      if (ctl.mean_upd) begin
        mean_reg <= mean_sum[SAMPLE_BITS-1:0];
      end
      if (ctl.finish) begin
        sq_dev_reg   <= sq_dev_next;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_reg     <= x_in;
      delta_neg <= diff_in[MAG_BITS-1];
      delta_mag <= mag_in;
    end
    if (ctl.finish) begin
      sample_count <= count_reg;
      running_mean <= PORT_BITS'(mean_reg);
      sum_sq_dev   <= sq_dev_next;
      minimum      <= PORT_BITS'(min_reg);
      maximum      <= PORT_BITS'(max_reg);
    end
  end

  `RMV_IMPLIES(a_min_le_max, result_valid, minimum <= maximum)
  `RMV_IMPLIES(a_mean_in_range, result_valid, minimum <= running_mean && running_mean <= maximum)
  `RMV_IMPLIES(a_count_nonzero, result_valid, sample_count != '0)
  `RMV_CHECK(a_busy_no_result_load, !(ctl.finish && start))

endmodule
